FILE: src/ckset_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ckset_pkg;

  // Fixed field widths of the request and result transactions.
  localparam int KEY_W     = 16;
  localparam int FUNC_W    = 2;
  localparam int CNT_OUT_W = 5;

  // Operation codes carried on the request channel.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_REMOVE   = 2'd1,
    FUNC_CONTAINS = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request key
    logic clr;         // empty the list
    logic scan_init;   // start walking from slot zero
    logic shift_init;  // start moving entries above the match down
    logic step;        // issue one slot read and advance the pointer
    logic shift_wr;    // write the slot read last cycle one place lower
    logic append;      // store the key at the end of the list
    logic dec;         // one entry fewer
    logic ok_set;      // record the result flag
    logic ok_val;
    logic out_load;    // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_zero;    // key on the request channel is the empty mark
    logic full;        // every slot is occupied
    logic at_end;      // pointer has reached the entry count
    logic match;       // slot read last cycle holds the key
    logic pend;        // a slot read is in flight
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/ckset_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ckset_dp
  import ckset_pkg::*;
#(
  parameter int SET_SLOTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [KEY_W-1:0]     in_key_code,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                sts,
  output logic                      out_ok,
  output logic [CNT_OUT_W-1:0]      out_entry_count
);

  localparam int CNT_W = $clog2(SET_SLOTS + 1);
  localparam int AW    = (SET_SLOTS > 1) ? $clog2(SET_SLOTS) : 1;

  logic [KEY_W-1:0]     mem [SET_SLOTS];
  logic [KEY_W-1:0]     key_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cidx_r, cidx_nxt;
  logic                 vld_r, vld_nxt;
  logic [KEY_W-1:0]     rdata_r;
  logic                 res_ok_r;
  logic                 out_ok_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic                 rd_en;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_W-1:0]     wr_data;
  logic                 full;

  assign full  = (count_r == CNT_W'(SET_SLOTS));
  assign rd_en = cmd.step && (idx_r < count_r);

  // Status back to the controller.
  assign sts.key_zero = (in_key_code == '0);
  assign sts.full     = full;
  assign sts.at_end   = (idx_r == count_r);
  assign sts.match    = vld_r && (rdata_r == key_r);
  assign sts.pend     = vld_r;

  // Write port: an append at the end, or one step of the compaction.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = key_r;
    if (cmd.append) begin
      wr_en = 1'b1;
    end else if (cmd.shift_wr && vld_r) begin
      wr_en   = 1'b1;
      wr_addr = cidx_r[AW-1:0] - AW'(1);
      wr_data = rdata_r;
    end
  end

  // Slot pointer, read pipeline and entry count.
  always_comb begin
    idx_nxt   = idx_r;
    cidx_nxt  = cidx_r;
    vld_nxt   = vld_r;
    count_nxt = count_r;
    if (cmd.shift_init) begin
      idx_nxt = cidx_r + CNT_W'(1);
      vld_nxt = 1'b0;
    end else if (cmd.scan_init) begin
      idx_nxt = '0;
      vld_nxt = 1'b0;
    end else if (cmd.step) begin
      vld_nxt = rd_en;
      if (rd_en) begin
        cidx_nxt = idx_r;
        idx_nxt  = idx_r + CNT_W'(1);
      end
    end
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      cidx_r  <= '0;
      vld_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      cidx_r  <= cidx_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // Slot memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[idx_r[AW-1:0]];
    end
  end

  // Request key, result flag and output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key_code;
    end
    if (cmd.ok_set) begin
      res_ok_r <= cmd.ok_val;
    end
    if (cmd.out_load) begin
      out_ok_r  <= res_ok_r;
      out_cnt_r <= CNT_OUT_W'(count_r);
    end
  end

  assign out_ok          = out_ok_r;
  assign out_entry_count = out_cnt_r;

endmodule

`default_nettype wire

FILE: src/ckset_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ckset_ctrl
  import ckset_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [FUNC_W-1:0] in_func,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dp_status_t        sts,
  output dp_cmd_t                cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  func_t  func_r, func_nxt;
  logic   out_valid_r, out_valid_nxt;
  func_t  in_op;

  assign in_op = func_t'(in_func);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          func_nxt = in_op;
          if (in_op == FUNC_CLEAR) begin
            cmd.clr    = 1'b1;
            cmd.ok_set = 1'b1;
            cmd.ok_val = 1'b1;
            state_nxt  = ST_RESP;
          end else if (sts.key_zero) begin
            // The empty mark matches the first free slot, if there is one.
            cmd.ok_set = 1'b1;
            cmd.ok_val = !sts.full;
            state_nxt  = ST_RESP;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.match) begin
          if (func_r == FUNC_REMOVE) begin
            cmd.shift_init = 1'b1;
            state_nxt      = ST_SHIFT;
          end else begin
            cmd.ok_set = 1'b1;
            cmd.ok_val = 1'b1;
            state_nxt  = ST_RESP;
          end
        end else if (sts.at_end) begin
          // Key is absent: an add appends it while there is room.
          cmd.ok_set = 1'b1;
          if (func_r == FUNC_ADD && !sts.full) begin
            cmd.append = 1'b1;
            cmd.ok_val = 1'b1;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_SHIFT: begin
        cmd.step     = 1'b1;
        cmd.shift_wr = 1'b1;
        if (sts.at_end && !sts.pend) begin
          cmd.dec    = 1'b1;
          cmd.ok_set = 1'b1;
          cmd.ok_val = 1'b1;
          state_nxt  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output transaction is pending until the consumer takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      func_r      <= FUNC_ADD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: src/compacting_key_set.sv
`timescale 1ns / 1ps
`default_nettype none

// Packed set of SET_SLOTS nonzero 16-bit key codes with add, remove, contains and
// clear requests, one result transaction per request carrying a flag and the entry
// count after the operation. Requests are taken one at a time. Clear and requests
// with key zero go from acceptance straight to the response state, which loads the
// result into the output register once the output is free; add and contains walk
// the stored entries from slot zero, and a remove also moves every entry behind the
// removed key one slot lower. The single slot memory is read one slot per cycle. A
// new request is accepted while a finished result still waits on the output.

module compacting_key_set
  import ckset_pkg::*;
#(
  parameter int SET_SLOTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [KEY_W-1:0]     in_key_code,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_ok,
  output logic [CNT_OUT_W-1:0]      out_entry_count
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequencer for the slot walk and the compaction.
  ckset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Slot memory, pointers and result registers.
  ckset_dp #(
    .SET_SLOTS (SET_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key_code     (in_key_code),
    .cmd             (cmd),
    .sts             (sts),
    .out_ok          (out_ok),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire
